// ----- design/rbeh_pkg.sv -----
// ----------------------------------------------------------------------------
// rbeh_pkg
// shared constants and types for the ray box first hit block
// ----------------------------------------------------------------------------
package rbeh_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TYPE_BITS_DEF  = 3;
    localparam int NUM_EDGES      = 4;

    localparam logic [1:0] SIDE_BOTTOM = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_TOP    = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    typedef struct packed {
        logic load;
        logic start_edge;
        logic div_step;
        logic mul_step;
        logic finish_edge;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic box_ok;
        logic edge_skip;
        logic div_done;
        logic mul_done;
        logic edge_hit;
        logic latched;
    } t_status;
endpackage

// ----- design/rbeh_datapath.sv -----
// ----------------------------------------------------------------------------
// rbeh_datapath
// edge operands, bit-serial divider, two multipliers, hit latch
// ----------------------------------------------------------------------------
module rbeh_datapath
    import rbeh_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int TYPE_BITS  = TYPE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [COORD_BITS-1:0] i_ox,
    input  logic signed [COORD_BITS-1:0] i_oy,
    input  logic signed [COORD_BITS-1:0] i_dx,
    input  logic signed [COORD_BITS-1:0] i_dy,
    input  logic        [COORD_BITS-2:0] i_len,
    input  logic        [TYPE_BITS-1:0]  i_wtype,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic        [COORD_BITS-2:0] i_bw,
    input  logic        [COORD_BITS-2:0] i_bh,
    input  logic        [TYPE_BITS-1:0]  i_btype,
    input  logic        [1:0]            i_side,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_px,
    output logic signed [COORD_BITS-1:0] o_py,
    output logic        [1:0]            o_side,
    output logic        [COORD_BITS-2:0] o_dist
);
    localparam int CB = COORD_BITS;
    localparam int NB = CB + 1;
    localparam int QB = NB + FRAC_BITS;
    localparam int CW = $clog2(QB + 1);
    localparam logic [CB:0] HALF = {2'b01, {(CB-1){1'b0}}};

    logic signed [CB-1:0] r_ox, r_oy, r_dx, r_dy, r_bx, r_by;
    logic [CB-2:0] r_len, r_bw, r_bh;
    logic r_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ox <= i_ox; r_oy <= i_oy; r_dx <= i_dx; r_dy <= i_dy;
            r_bx <= i_bx; r_by <= i_by; r_bw <= i_bw; r_bh <= i_bh;
            r_len <= i_len;
            r_ok  <= (i_btype == i_wtype) && (i_bw != '0) && (i_bh != '0);
        end
    end

    // edge geometry
    logic vert;
    logic signed [CB+1:0] bx_e, by_e, hx_e, hy_e, line_v, num_v, den_v;
    always_comb begin
        vert   = i_side[0];
        bx_e   = (CB+2)'(r_bx);
        by_e   = (CB+2)'(r_by);
        hx_e   = bx_e + (CB+2)'({1'b0, r_bw});
        hy_e   = by_e + (CB+2)'({1'b0, r_bh});
        if (vert) begin
            line_v = (i_side == SIDE_RIGHT) ? hx_e : bx_e;
            num_v  = line_v - (CB+2)'(r_ox);
            den_v  = (CB+2)'(r_dx);
        end else begin
            line_v = (i_side == SIDE_BOTTOM) ? by_e : hy_e;
            num_v  = line_v - (CB+2)'(r_oy);
            den_v  = (CB+2)'(r_dy);
        end
    end
    logic skip_v;
    assign skip_v = (den_v == '0) || ((num_v != '0) && (num_v[CB+1] != den_v[CB+1]));

    // restoring divider over n * 2^FRAC, one quotient bit a cycle
    logic [QB-1:0] r_n;
    logic [NB:0]   r_r;
    logic [CB-1:0] r_d;
    logic [QB-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic [NB:0]   trial;
    logic [NB+1:0] rsh;
    logic [NB:0]   num_mag;
    assign num_mag = num_v[CB+1] ? (NB+1)'(-num_v) : (NB+1)'(num_v);
    assign rsh   = {r_r, r_n[QB-1]};
    assign trial = (NB+1)'(rsh - (NB+2)'(r_d));
    logic ge;
    assign ge = rsh >= (NB+2)'(r_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_edge) begin
            r_n   <= {num_mag[NB-1:0], {FRAC_BITS{1'b0}}};
            r_d   <= den_v[CB+1] ? CB'(-den_v) : CB'(den_v);
            r_r   <= '0;
            r_q   <= '0;
            r_cnt <= CW'(QB);
        end else if (i_cmd.div_step) begin
            r_n   <= {r_n[QB-2:0], 1'b0};
            r_r   <= ge ? trial : (NB+1)'(rsh);
            r_q   <= {r_q[QB-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end
    logic [CB:0] t_sat;
    assign t_sat = (r_q >= QB'(HALF)) ? HALF : r_q[CB:0];

    // point: product of |d| and t, truncated, saturated
    logic [2*CB:0] r_mx, r_my;
    logic [CB:0]   r_t;
    logic          r_mdone;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_step) begin
            r_t  <= t_sat;
            r_mx <= (2*CB+1)'(r_dx[CB-1] ? CB'(-r_dx) : CB'(r_dx)) * (2*CB+1)'(t_sat);
            r_my <= (2*CB+1)'(r_dy[CB-1] ? CB'(-r_dy) : CB'(r_dy)) * (2*CB+1)'(t_sat);
        end
        if (!i_rst_n) r_mdone <= 1'b0;
        else r_mdone <= i_cmd.mul_step;
    end

    function automatic logic signed [CB-1:0] adv(input logic signed [CB-1:0] o,
                                                 input logic s,
                                                 input logic [2*CB:0] m);
        logic [2*CB:0] sh;
        logic [CB:0]   p;
        logic signed [CB+2:0] v;
        logic signed [CB+2:0] hi, lo;
        sh = m >> FRAC_BITS;
        p  = (sh > (2*CB+1)'(HALF)) ? HALF : sh[CB:0];
        v  = s ? ((CB+3)'(o) - (CB+3)'(p)) : ((CB+3)'(o) + (CB+3)'(p));
        hi = (CB+3)'({1'b0, {(CB-1){1'b1}}});
        lo = -(CB+3)'(HALF);
        if (v > hi) v = hi;
        else if (v < lo) v = lo;
        return CB'(v);
    endfunction

    logic signed [CB-1:0] px_v, py_v;
    logic signed [CB+1:0] along, lo_v, hi_v;
    assign px_v = adv(r_ox, r_dx[CB-1], r_mx);
    assign py_v = adv(r_oy, r_dy[CB-1], r_my);
    always_comb begin
        if (vert) begin
            along = (CB+2)'(py_v); lo_v = by_e; hi_v = hy_e;
        end else begin
            along = (CB+2)'(px_v); lo_v = bx_e; hi_v = hx_e;
        end
    end
    logic hit_v;
    assign hit_v = (r_t <= (CB+1)'(r_len)) && (along >= lo_v) && (along <= hi_v);

    logic r_hit;
    logic signed [CB-1:0] r_px, r_py;
    logic [1:0] r_side;
    logic [CB-2:0] r_dist;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_hit <= 1'b0; r_px <= '0; r_py <= '0; r_side <= '0; r_dist <= '0;
        end else if (i_cmd.finish_edge && hit_v) begin
            r_hit <= 1'b1; r_px <= px_v; r_py <= py_v; r_side <= i_side;
            r_dist <= r_t[CB-2:0];
        end
    end

    assign o_status.box_ok    = r_ok;
    assign o_status.edge_skip = skip_v;
    assign o_status.div_done  = (r_cnt == '0);
    assign o_status.mul_done  = r_mdone;
    assign o_status.edge_hit  = hit_v;
    assign o_status.latched   = r_hit;
    assign o_hit  = r_hit;
    assign o_px   = r_px;
    assign o_py   = r_py;
    assign o_side = r_side;
    assign o_dist = r_dist;
endmodule

// ----- design/rbeh_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbeh_ctrl
// sequencer over the edges of each box (bottom, right, top, left) and the input and output handshakes
// ----------------------------------------------------------------------------
module rbeh_ctrl
    import rbeh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_side,
    output t_cmd       o_cmd,
    input  t_status    i_status
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EDGE = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_side, n_side;
    logic       r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_side <= '0; r_last <= 1'b0;
        end else begin
            r_state <= n_state; r_side <= n_side; r_last <= n_last;
        end
    end

    always_comb begin
        n_state = r_state; n_side = r_side; n_last = r_last;
        o_cmd = '0;
        o_in_ready = 1'b0; o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1; n_last = i_in_last; n_side = SIDE_BOTTOM;
                    n_state = i_status.latched ? S_END : S_EDGE;
                end
            end
            S_EDGE: begin
                if (!i_status.box_ok) n_state = S_END;
                else if (i_status.edge_skip) begin
                    n_side = r_side + 1'b1;
                    if (r_side == SIDE_LEFT) n_state = S_END;
                end else begin
                    o_cmd.start_edge = 1'b1; n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.mul_step = 1'b1; n_state = S_MUL;
                end else o_cmd.div_step = 1'b1;
            end
            S_MUL: if (i_status.mul_done) n_state = S_CHK;
            S_CHK: begin
                o_cmd.finish_edge = 1'b1;
                n_side = r_side + 1'b1;
                if (i_status.edge_hit || r_side == SIDE_LEFT) n_state = S_END;
                else n_state = S_EDGE;
            end
            S_END: n_state = r_last ? S_OUT : S_IDLE;
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
    assign o_side = r_side;

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.start_edge, o_cmd.div_step, o_cmd.mul_step,
                  o_cmd.finish_edge, o_cmd.emit})) else $error("cmd overlap");
    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_last) else $error("emit without last");
`endif
endmodule

// ----- design/ray_box_edge_first_hit.sv -----
// ----------------------------------------------------------------------------
// ray_box_edge_first_hit
// 2d ray against a run of boxes, first edge hit latched, result on last box
// sequence: per box a load, then each edge in turn until one hits, unless type
// or size rules the box out or a hit is already latched; a tested edge runs the
// bit-serial divider, then multiply and check; a skipped edge is not divided
// throughput: one box at a time; result valid once the last box is done
// reset: synchronous active low, clears latch, sequencer and output valid
// ----------------------------------------------------------------------------
module ray_box_edge_first_hit
    import rbeh_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int TYPE_BITS  = TYPE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // origin_x, origin_y, dir_x, dir_y, ray_length, wanted_type, box_x, box_y,
    // box_width, box_height, box_type
    input  logic [((9*COORD_BITS-3+2*TYPE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // hit, point_x, point_y, edge_side, hit_distance
    output logic [((3*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    localparam int CB = COORD_BITS;
    localparam int TB = TYPE_BITS;
    localparam int OW = ((3*CB+2+7)/8)*8;

    t_cmd cmd;
    t_status st;
    logic [1:0] side, o_side;
    logic hit;
    logic signed [CB-1:0] px, py;
    logic [CB-2:0] hit_dist;

    rbeh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_last(s_axis_tlast),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .o_side(side), .o_cmd(cmd), .i_status(st)
    );

    rbeh_datapath #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .TYPE_BITS(TB)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ox(s_axis_tdata[CB-1:0]),
        .i_oy(s_axis_tdata[2*CB-1:CB]),
        .i_dx(s_axis_tdata[3*CB-1:2*CB]),
        .i_dy(s_axis_tdata[4*CB-1:3*CB]),
        .i_len(s_axis_tdata[5*CB-2:4*CB]),
        .i_wtype(s_axis_tdata[5*CB-1+TB-1:5*CB-1]),
        .i_bx(s_axis_tdata[6*CB-1+TB-1:5*CB-1+TB]),
        .i_by(s_axis_tdata[7*CB-1+TB-1:6*CB-1+TB]),
        .i_bw(s_axis_tdata[8*CB-2+TB-1:7*CB-1+TB]),
        .i_bh(s_axis_tdata[9*CB-3+TB-1:8*CB-2+TB]),
        .i_btype(s_axis_tdata[9*CB-3+2*TB-1:9*CB-3+TB]),
        .i_side(side), .i_cmd(cmd), .o_status(st),
        .o_hit(hit), .o_px(px), .o_py(py), .o_side(o_side), .o_dist(hit_dist)
    );

    assign m_axis_tdata = OW'({hit_dist, o_side, py, px, hit});
endmodule
